@@ hdl/lssl_pkg.sv @@
`timescale 1ns / 1ps
package lssl_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int LINE_BUFFER = 1000;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = $clog2(PATTERN_MAX + 1);
    localparam int PAT_IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int PAT_W      = PATTERN_MAX * BYTE_W;
    localparam int LINE_W     = 24;
    localparam int COL_W      = 10;
    localparam int CFG_W      = 64;
    localparam int ADDR_W     = 5;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;
    localparam logic [LINE_W-1:0] LINE_MAX     = {LINE_W{1'b1}};
    localparam logic [COL_W-1:0]  LINE_LIMIT   = COL_W'(LINE_BUFFER - 1);
    localparam logic [LEN_W-1:0]  LEN_CAP      = LEN_W'(PATTERN_MAX);

    // Register index, taken from paddr[4:3]
    typedef enum logic [1:0] {
        REG_PATTERN_LOW  = 2'd0,
        REG_PATTERN_HIGH = 2'd1,
        REG_PATTERN_LEN  = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic              found;
        logic [LINE_W-1:0] line_number;
        logic [COL_W-1:0]  column;
    } lssl_result_t;

    function automatic logic [BYTE_W-1:0] pat_byte_at(
        input logic [PAT_W-1:0]     pattern,
        input logic [PAT_IDX_W-1:0] idx
    );
        pat_byte_at = pattern[idx*BYTE_W +: BYTE_W];
    endfunction

endpackage

@@ hdl/lssl_cell.sv @@
`timescale 1ns / 1ps
module lssl_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        shift_en,
    input  logic                        clear,
    input  logic [lssl_pkg::BYTE_W-1:0] byte_in,
    input  logic [lssl_pkg::BYTE_W-1:0] pat_byte,
    output logic [lssl_pkg::BYTE_W-1:0] byte_out,
    output logic                        eq
);
    import lssl_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;

    always_comb begin
        byte_next = byte_reg;
        if (clear) begin
            byte_next = '0;
        end else if (shift_en) begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= '0;
        end else begin
            byte_reg <= byte_next;
        end
    end

    // compare the byte this cell takes on the shift
    assign eq       = (byte_in == pat_byte);
    assign byte_out = byte_reg;

endmodule

@@ hdl/lssl_line_track.sv @@
`timescale 1ns / 1ps
module lssl_line_track (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        text_valid,
    input  logic                        eof_valid,
    input  logic [lssl_pkg::BYTE_W-1:0] text_byte,
    input  logic [lssl_pkg::LEN_W-1:0]  len,
    input  logic                        window_eq,
    output logic                        res_valid,
    output lssl_pkg::lssl_result_t      res,
    output logic                        match_done
);
    import lssl_pkg::*;

    logic [LINE_W-1:0] line_reg, line_next;
    logic [COL_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [COL_W-1:0]  cnt_inc;
    logic [COL_W-1:0]  len_ext;

    assign cnt_inc = cnt_reg + COL_W'(1);
    assign len_ext = COL_W'(len);

    always_comb begin
        line_next = line_reg;
        cnt_next  = cnt_reg;
        done_next = done_reg;
        res_valid = 1'b0;
        res       = '0;
        if (eof_valid) begin
            res_valid = !done_reg;
            line_next = LINE_W'(1);
            cnt_next  = '0;
            done_next = 1'b0;
        end else if (text_valid && !done_reg) begin
            cnt_next = cnt_inc;
            if (len == '0) begin
                res_valid       = 1'b1;
                done_next       = 1'b1;
                res.found       = 1'b1;
                res.line_number = line_reg;
                res.column      = COL_W'(1);
            end else if (cnt_inc >= len_ext && window_eq) begin
                res_valid       = 1'b1;
                done_next       = 1'b1;
                res.found       = 1'b1;
                res.line_number = line_reg;
                res.column      = cnt_inc - len_ext + COL_W'(1);
            end else if (text_byte == NEWLINE_BYTE || cnt_inc >= LINE_LIMIT) begin
                cnt_next = '0;
                if (line_reg != LINE_MAX) begin
                    line_next = line_reg + LINE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg <= LINE_W'(1);
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            line_reg <= line_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign match_done = done_reg;

endmodule

@@ hdl/line_substring_locator_unit.sv @@
`timescale 1ns / 1ps
// Line substring locator: finds the first occurrence of a pattern of up to
// 16 bytes in a text streamed in one byte per transfer, searching line by line.
// Input stream (s_): s_tdata = data_byte, s_tuser = req_type (0 text, 1 end
// of file). Result stream (m_): m_tuser = found, m_tdata = line_number
// [23:0], column [33:24], zero padding [39:34]. At most one result per item:
// a hit on the byte that completes the first match, or not-found on end of
// file when nothing matched. End of file resets line to one, clears column and window.
// The APB port holds pattern_low (0x00), pattern_high (0x08) and
// pattern_len (0x10); write it only while the stream is idle.
// Throughput: one item per cycle while s_tready is high; a row of 16 byte cells
// shifts and compares in the same cycle, so window update and match test happen together.
// Result path: a result is registered in the output register, or in the skid entry if that one waits.
// Stall: a two-entry output buffer (output register plus skid entry) keeps
// s_tready high while one result waits; a second waiting result drops
// s_tready until the receiver takes a transfer.
// Reset: synchronous, active low; pattern registers return to zero,
// line count to one, and the output buffer empties.
module line_substring_locator_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] data_byte
    input  logic                         s_tuser,   // [0] req_type
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [39:0]                  m_tdata,   // [23:0] line_number, [33:24] column
    output logic                         m_tuser,   // [0] found
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lssl_pkg::ADDR_W-1:0]  paddr,
    input  logic [lssl_pkg::CFG_W-1:0]   pwdata,
    output logic [lssl_pkg::CFG_W-1:0]   prdata,
    output logic                         pready
);
    import lssl_pkg::*;

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0] pat_low_reg, pat_high_reg;
    logic [LEN_W-1:0] pat_len_reg;
    logic             cfg_write;
    reg_index_t       cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_index_t'(paddr[4:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_PATTERN_LOW:  pat_low_reg  <= pwdata;
                REG_PATTERN_HIGH: pat_high_reg <= pwdata;
                REG_PATTERN_LEN:  pat_len_reg  <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_PATTERN_LOW:  prdata = pat_low_reg;
            REG_PATTERN_HIGH: prdata = pat_high_reg;
            REG_PATTERN_LEN:  prdata = CFG_W'(pat_len_reg);
            default:          prdata = '0;
        endcase
    end

    // lengths above the cell count act as a full-length pattern
    logic [LEN_W-1:0] act_len;
    logic [PAT_W-1:0] pattern;

    assign act_len = (pat_len_reg > LEN_CAP) ? LEN_CAP : pat_len_reg;
    assign pattern = PAT_W'({pat_high_reg, pat_low_reg});

    // ---------------- input side ----------------
    logic s_acc, text_valid, eof_valid, match_done;
    logic skid_valid_reg;

    assign s_tready   = !skid_valid_reg;
    assign s_acc      = s_tvalid && s_tready;
    assign text_valid = s_acc && !s_tuser;
    assign eof_valid  = s_acc && s_tuser;

    // ---------------- cell row ----------------
    // Cell k holds the k-th most recent byte; on a shift it compares the
    // byte it takes against pattern byte len-1-k. Cells at or past len
    // do not take part in the match.
    logic [BYTE_W-1:0]      chain [PATTERN_MAX+1];
    logic [PATTERN_MAX-1:0] cell_eq;
    logic [PATTERN_MAX-1:0] cell_used;
    logic                   shift_en;
    logic                   window_eq;

    assign shift_en = text_valid && !match_done;
    assign chain[0] = s_tdata;

    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++) begin : g_cell
            logic [LEN_W-1:0]  pidx;
            logic [BYTE_W-1:0] pbyte;

            assign pidx         = act_len - LEN_W'(1) - LEN_W'(k);
            assign pbyte        = pat_byte_at(pattern, pidx[PAT_IDX_W-1:0]);
            assign cell_used[k] = (LEN_W'(k) < act_len);

            lssl_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .clear    (eof_valid),
                .byte_in  (chain[k]),
                .pat_byte (pbyte),
                .byte_out (chain[k+1]),
                .eq       (cell_eq[k])
            );
        end
    endgenerate

    assign window_eq = &(cell_eq | ~cell_used);

    // ---------------- line and column tracking ----------------
    logic         res_valid;
    lssl_result_t res;

    lssl_line_track u_track (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .text_valid (text_valid),
        .eof_valid  (eof_valid),
        .text_byte  (s_tdata),
        .len        (act_len),
        .window_eq  (window_eq),
        .res_valid  (res_valid),
        .res        (res),
        .match_done (match_done)
    );

    // ---------------- output buffer ----------------
    logic         m_valid_reg;
    lssl_result_t m_res_reg, skid_res_reg;
    logic         m_pop;

    assign m_pop = m_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!m_valid_reg || m_pop) begin
                // advance the skid entry first, else take the new result
                if (skid_valid_reg) begin
                    m_valid_reg    <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    m_valid_reg <= res_valid;
                end
            end else if (res_valid) begin
                // hold the waiting result, park the new one
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_pop) begin
            if (skid_valid_reg) begin
                m_res_reg <= skid_res_reg;
            end else if (res_valid) begin
                m_res_reg <= res;
            end
        end else if (res_valid) begin
            skid_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.found;
    assign m_tdata  = {6'b0, m_res_reg.column, m_res_reg.line_number};

    // ---------------- assertions ----------------
    a_skid_needs_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry valid while output register empty");

    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("not-found result carries nonzero line or column");

    a_found_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[23:0] != '0 && m_tdata[33:24] != '0))
        else $error("found result with zero line or column");

    a_eof_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        eof_valid |=> !match_done)
        else $error("match flag survives end of file");

endmodule
